// ===== src/rc_pkg.sv =====
`default_nettype none
package rc_pkg;

    localparam int VALUE_BITS = 64;
    localparam int MAX_DIGITS = 64;

    localparam int BASE_W    = 6;
    localparam int CHAR_W    = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CNT_W     = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W     = $clog2(MAX_DIGITS);
    localparam int STEP_W    = $clog2(VALUE_BITS);

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [BASE_W-1:0]     base_t;
    typedef logic [CHAR_W-1:0]     char_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

    localparam cfg_idx_t REG_SOURCE_BASE = cfg_idx_t'(0);
    localparam cfg_idx_t REG_TARGET_BASE = cfg_idx_t'(1);

    localparam base_t SOURCE_BASE_RESET = base_t'(10);
    localparam base_t TARGET_BASE_RESET = base_t'(16);
    localparam base_t BASE_MIN          = base_t'(2);
    localparam base_t BASE_MAX          = base_t'(36);
    localparam base_t DIGIT_TEN         = base_t'(10);

    localparam char_t CHAR_ZERO = 8'h30;
    localparam char_t CHAR_NINE = 8'h39;
    localparam char_t CHAR_A    = 8'h41;
    localparam char_t CHAR_Z    = 8'h5A;

    typedef struct packed {
        logic in_ready;
        logic acc_update;
        logic acc_clear;
        logic div_start;
        logic div_step;
        logic digit_wr;
        logic emit_init;
        logic rd_issue;
        logic out_load_echo;
        logic out_load_digit;
        logic ptr_dec;
        logic emit_done;
    } rc_cmd_t;

    typedef struct packed {
        logic echo;
        logic in_last;
        logic out_free;
        logic div_last_step;
        logic q_zero_after;
        logic count_full_after;
        logic ptr_zero;
    } rc_stat_t;

    function automatic base_t char_worth(input char_t c);
        base_t d;
        d = '0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            d = base_t'(c - CHAR_ZERO);
        end
        else if (c >= CHAR_A && c <= CHAR_Z)
        begin
            d = base_t'(c - CHAR_A) + DIGIT_TEN;
        end
        return d;
    endfunction

    function automatic char_t worth_char(input base_t d);
        char_t c;
        if (d < DIGIT_TEN)
        begin
            c = CHAR_ZERO + char_t'(d);
        end
        else
        begin
            c = CHAR_A + char_t'(d - DIGIT_TEN);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== src/rc_in_if.sv =====
`default_nettype none
interface rc_in_if import rc_pkg::*; ();
    logic  valid;
    logic  ready;
    char_t char_code;
    logic  last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface
`default_nettype wire

// ===== src/rc_out_if.sv =====
`default_nettype none
interface rc_out_if import rc_pkg::*; ();
    logic  valid;
    logic  ready;
    char_t out_char;
    logic  out_last;

    modport source (output valid, output out_char, output out_last, input ready);
    modport sink   (input valid, input out_char, input out_last, output ready);
endinterface
`default_nettype wire

// ===== src/rc_cfg_if.sv =====
`default_nettype none
interface rc_cfg_if import rc_pkg::*; ();
    logic     valid;
    logic     ready;
    cfg_idx_t index;
    base_t    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== src/radix_converter.sv =====
// channel  | role   | payload              | accepted when
// chars    | sink   | char_code, last_char | chars.valid & chars.ready
// digits   | source | out_char, out_last   | digits.valid & digits.ready
// cfg      | sink   | index, data          | cfg.valid & cfg.ready (always ready)
//
// characters are taken one per cycle while the value accumulates
// on a last character, when the bases differ and are valid, each output digit
// comes from the single restoring divider into the digit store, then is read back
// and emitted most significant first; the input is held until the last is emitted
// reset sets the bases to 10 and 16 and clears the accumulator
// a digit waiting in the output register stalls emission until digits.ready
`default_nettype none
module radix_converter import rc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    rc_in_if.sink     chars,
    rc_out_if.source  digits,
    rc_cfg_if.sink    cfg
);

    rc_cmd_t  cmd;
    rc_stat_t stat;
    logic     out_valid;
    char_t    out_char;
    logic     out_last;

    rc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (chars.valid),
        .stat     (stat),
        .cmd      (cmd)
    );

    rc_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_char   (chars.char_code),
        .in_last   (chars.last_char),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .out_ready (digits.ready),
        .out_valid (out_valid),
        .out_char  (out_char),
        .out_last  (out_last)
    );

    assign chars.ready     = cmd.in_ready;
    assign cfg.ready       = 1'b1;
    assign digits.valid    = out_valid;
    assign digits.out_char = out_char;
    assign digits.out_last = out_last;

endmodule
`default_nettype wire

// ===== src/rc_ctrl.sv =====
`default_nettype none
module rc_ctrl import rc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire rc_stat_t stat,
    output rc_cmd_t       cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        fire       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = stat.echo ? stat.out_free : 1'b1;
                fire         = in_valid && cmd.in_ready;
                if (fire)
                begin
                    if (stat.echo)
                    begin
                        cmd.out_load_echo = 1'b1;
                        cmd.acc_clear     = stat.in_last;
                    end
                    else if (stat.in_last)
                    begin
                        cmd.div_start = 1'b1;
                        cmd.acc_clear = 1'b1;
                        state_next    = S_DIV;
                    end
                    else
                    begin
                        cmd.acc_update = 1'b1;
                    end
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last_step)
                begin
                    cmd.digit_wr = 1'b1;
                    if (stat.q_zero_after || stat.count_full_after)
                    begin
                        cmd.emit_init = 1'b1;
                        state_next    = S_RD;
                    end
                end
            end
            S_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load_digit = 1'b1;
                    if (stat.ptr_zero)
                    begin
                        cmd.emit_done = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        cmd.ptr_dec = 1'b1;
                        state_next  = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== src/rc_dpath.sv =====
`default_nettype none
module rc_dpath import rc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire rc_cmd_t  cmd,
    output rc_stat_t      stat,
    input  wire char_t    in_char,
    input  wire logic     in_last,
    input  wire logic     cfg_we,
    input  wire cfg_idx_t cfg_index,
    input  wire base_t    cfg_data,
    input  wire logic     out_ready,
    output logic          out_valid,
    output char_t         out_char,
    output logic          out_last
);

    base_t                    source_base_reg;
    base_t                    target_base_reg;
    value_t                   acc_reg;
    value_t                   acc_next;
    logic [VALUE_BITS+BASE_W-1:0] prod;
    value_t                   q_reg;
    value_t                   q_step;
    base_t                    r_reg;
    base_t                    r_step;
    logic [BASE_W:0]          trial;
    logic                     trial_ge;
    logic [STEP_W-1:0]        step_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [IDX_W-1:0]         ptr_reg;
    base_t                    digit_mem [MAX_DIGITS];
    base_t                    rd_data_reg;
    logic                     out_valid_reg;
    char_t                    out_char_reg;
    logic                     out_last_reg;
    logic                     src_ok;
    logic                     tgt_ok;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_base_reg <= SOURCE_BASE_RESET;
            target_base_reg <= TARGET_BASE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SOURCE_BASE: source_base_reg <= cfg_data;
                REG_TARGET_BASE: target_base_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign src_ok = (source_base_reg >= BASE_MIN) && (source_base_reg <= BASE_MAX);
    assign tgt_ok = (target_base_reg >= BASE_MIN) && (target_base_reg <= BASE_MAX);

    // accumulator
    assign prod     = acc_reg * source_base_reg;
    assign acc_next = prod[VALUE_BITS-1:0] + VALUE_BITS'(char_worth(in_char));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_clear)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_update)
        begin
            acc_reg <= acc_next;
        end
    end

    // restoring divider, one quotient bit a cycle
    assign trial    = {r_reg, q_reg[VALUE_BITS-1]};
    assign trial_ge = trial >= {1'b0, target_base_reg};
    assign r_step   = trial_ge ? base_t'(trial - {1'b0, target_base_reg}) : trial[BASE_W-1:0];
    assign q_step   = {q_reg[VALUE_BITS-2:0], trial_ge};

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            q_reg <= acc_next;
            r_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            q_reg <= q_step;
            r_reg <= stat.div_last_step ? base_t'(0) : r_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            count_reg <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            if (cmd.div_start)
            begin
                step_reg  <= '0;
                count_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                step_reg <= stat.div_last_step ? STEP_W'(0) : step_reg + STEP_W'(1);
                if (cmd.digit_wr)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            else if (cmd.emit_done)
            begin
                count_reg <= '0;
            end
            if (cmd.emit_init)
            begin
                ptr_reg <= count_reg[IDX_W-1:0];
            end
            else if (cmd.ptr_dec)
            begin
                ptr_reg <= ptr_reg - IDX_W'(1);
            end
        end
    end

    // digit store
    always_ff @(posedge clk)
    begin
        if (cmd.digit_wr)
        begin
            digit_mem[count_reg[IDX_W-1:0]] <= r_step;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= digit_mem[ptr_reg];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load_echo || cmd.out_load_digit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load_echo)
        begin
            out_char_reg <= in_char;
            out_last_reg <= in_last;
        end
        else if (cmd.out_load_digit)
        begin
            out_char_reg <= worth_char(rd_data_reg);
            out_last_reg <= (ptr_reg == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

    always_comb
    begin
        stat.echo             = (source_base_reg == target_base_reg) || !src_ok || !tgt_ok;
        stat.in_last          = in_last;
        stat.out_free         = !out_valid_reg || out_ready;
        stat.div_last_step    = (step_reg == STEP_W'(VALUE_BITS - 1));
        stat.q_zero_after     = (q_step == '0);
        stat.count_full_after = (count_reg + CNT_W'(1) == CNT_W'(MAX_DIGITS));
        stat.ptr_zero         = (ptr_reg == '0);
    end

endmodule
`default_nettype wire
